// ===== rtl/lrupr_pkg.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement - shared types and constants
// Control word for one recency cell, widths of the fixed fields.
// ----------------------------------------------------------------------------
package lrupr_pkg;

   // fixed field widths
   localparam int CFG_W   = 4;
   localparam int FAULT_W = 16;

   localparam logic [CFG_W-1:0]   CFG_RESET = 4'd8;
   localparam logic [FAULT_W-1:0] FAULT_MAX = '1;

   // per-cell control: take the offered entry, or drop validity on restart
   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctrl_type;

endpackage

// ===== rtl/lru_page_replacement_core.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement core
// Fully associative page frame set with least-recently-used replacement.
// ----------------------------------------------------------------------------
// One request is taken per clock cycle and its response appears in the output
// register on the next cycle; a waiting response does not hold up the next
// request unless the response side is stalling. The frames live in a row of
// FRAMES recency cells ordered most recent first: a request picks one cell
// (the hit, the next free place, or the deepest replaceable frame), the new
// entry enters the head and each cell after the head, down to and including
// the picked one, takes its neighbour's contents in the same cycle.
// frames_in_use is written through the csr port (always ready); the user must
// write it only while idle, which the block does not enforce; 0 acts as 1
// and values above FRAMES act as FRAMES.
// ----------------------------------------------------------------------------
module lru_page_replacement_core #(
   parameter int FRAMES    = 8,
   parameter int PAGE_BITS = 16,
   localparam int SLOT_W   = (FRAMES > 1) ? $clog2(FRAMES) : 1,
   localparam int CNT_W    = $clog2(FRAMES + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   // request channel
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [PAGE_BITS-1:0]        req_page_number,
   input  logic                        req_restart,
   // response channel
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic                        rsp_fault,
   output logic [SLOT_W-1:0]           rsp_frame_slot,
   output logic                        rsp_evicted_valid,
   output logic [PAGE_BITS-1:0]        rsp_evicted_page,
   output logic [CNT_W-1:0]            rsp_frames_occupied,
   output logic [lrupr_pkg::FAULT_W-1:0] rsp_fault_total,
   // register write channel
   input  logic                        csr_valid,
   output logic                        csr_ready,
   input  logic [lrupr_pkg::CFG_W-1:0] csr_frames_in_use
);

   import lrupr_pkg::*;

   localparam int LIM_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam logic [LIM_W-1:0] LIM_MAX = LIM_W'(FRAMES);
   localparam logic [LIM_W-1:0] LIM_MIN = LIM_W'(1);

   // configuration
   logic [CFG_W-1:0] cfg_ff, cfg_in;
   logic [LIM_W-1:0] limit;

   // bookkeeping
   logic [CNT_W-1:0]   fill_ff, fill_in, fill_eff;
   logic [FAULT_W-1:0] faults_ff, faults_in, faults_eff;

   // response register
   logic                 rsp_valid_ff;
   logic                 fault_ff;
   logic [SLOT_W-1:0]    slot_ff;
   logic                 ev_valid_ff;
   logic [PAGE_BITS-1:0] ev_page_ff;
   logic [CNT_W-1:0]     occ_ff;
   logic [FAULT_W-1:0]   total_ff;

   // cell row
   logic [FRAMES-1:0]    cell_valid, cell_match, cell_cand;
   logic [SLOT_W-1:0]    cell_slot [FRAMES];
   logic [PAGE_BITS-1:0] cell_page [FRAMES];
   logic [FRAMES-1:0]    hit_vec, victim, fill_pos, sel;
   logic [FRAMES:0]      cand_below, sel_below;

   logic                 accept, hit, do_fill, do_replace;
   logic [SLOT_W-1:0]    sel_slot, new_slot;
   logic [PAGE_BITS-1:0] victim_page;

   assign accept    = req_valid & ~req_stall;
   // output register parts the two sides: stall only while a response is held
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign csr_ready = 1'b1;

   // clamp the frame limit to 1..FRAMES
   always_comb begin
      if (cfg_ff == '0) begin
         limit = LIM_MIN;
      end else if (LIM_W'(cfg_ff) > LIM_MAX) begin
         limit = LIM_MAX;
      end else begin
         limit = LIM_W'(cfg_ff);
      end
   end

   // restart wipes the frames before this request is looked up
   assign fill_eff   = req_restart ? '0 : fill_ff;
   assign faults_eff = req_restart ? '0 : faults_ff;
   assign hit_vec    = req_restart ? '0 : cell_match;
   assign hit        = |hit_vec;
   assign do_fill    = ~hit && (LIM_W'(fill_eff) < limit);
   assign do_replace = ~hit & ~do_fill;

   // priority ripples, tail to head
   assign cand_below[FRAMES] = 1'b0;
   assign sel_below[FRAMES]  = 1'b0;

   for (genvar k = 0; k < FRAMES; k++) begin : g_row
      cell_ctrl_type        ctrl;
      logic                 d_valid;
      logic [SLOT_W-1:0]    d_slot;
      logic [PAGE_BITS-1:0] d_page;

      // deepest replaceable frame is the least recently used one
      assign victim[k]     = cell_cand[k] & ~cand_below[k+1];
      assign cand_below[k] = cell_cand[k] | cand_below[k+1];
      assign fill_pos[k]   = (fill_eff == CNT_W'(k));
      assign sel[k]        = hit ? hit_vec[k] : (do_fill ? fill_pos[k] : victim[k]);
      assign sel_below[k]  = sel[k] | sel_below[k+1];

      // head takes the new entry, cells down to the picked one shift by one
      if (k == 0) begin : g_head
         assign d_valid = 1'b1;
         assign d_slot  = new_slot;
         assign d_page  = req_page_number;
         assign ctrl.load = accept;
      end else begin : g_body
         assign d_valid = cell_valid[k-1];
         assign d_slot  = cell_slot[k-1];
         assign d_page  = cell_page[k-1];
         assign ctrl.load = accept & sel_below[k];
      end
      assign ctrl.clear = accept & req_restart;

      lrupr_cell #(
         .PAGE_BITS (PAGE_BITS),
         .SLOT_W    (SLOT_W),
         .LIM_W     (LIM_W)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .d_valid   (d_valid),
         .d_slot    (d_slot),
         .d_page    (d_page),
         .look_page (req_page_number),
         .limit     (limit),
         .q_valid   (cell_valid[k]),
         .q_slot    (cell_slot[k]),
         .q_page    (cell_page[k]),
         .match     (cell_match[k]),
         .cand      (cell_cand[k])
      );
   end

   // picked cell's slot and the replaced page (selects are one-hot)
   always_comb begin
      sel_slot    = '0;
      victim_page = '0;
      for (int i = 0; i < FRAMES; i++) begin
         if (sel[i]) begin
            sel_slot = sel_slot | cell_slot[i];
         end
         if (victim[i]) begin
            victim_page = victim_page | cell_page[i];
         end
      end
   end

   // a fill takes the next free slot in order
   assign new_slot = do_fill ? fill_eff[SLOT_W-1:0] : sel_slot;

   assign fill_in   = do_fill ? fill_eff + CNT_W'(1) : fill_eff;
   assign faults_in = (~hit && (faults_eff != FAULT_MAX)) ? faults_eff + FAULT_W'(1)
                                                          : faults_eff;
   assign cfg_in    = (csr_valid & csr_ready) ? csr_frames_in_use : cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff       <= CFG_RESET;
         fill_ff      <= '0;
         faults_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (accept) begin
            fill_ff      <= fill_in;
            faults_ff    <= faults_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fault_ff    <= ~hit;
         slot_ff     <= new_slot;
         ev_valid_ff <= do_replace;
         ev_page_ff  <= do_replace ? victim_page : '0;
         occ_ff      <= fill_in;
         total_ff    <= faults_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_fault           = fault_ff;
   assign rsp_frame_slot      = slot_ff;
   assign rsp_evicted_valid   = ev_valid_ff;
   assign rsp_evicted_page    = ev_page_ff;
   assign rsp_frames_occupied = occ_ff;
   assign rsp_fault_total     = total_ff;

endmodule

// ===== rtl/lrupr_cell.sv =====
// ----------------------------------------------------------------------------
// LRU page replacement - recency cell
// One place of the recency stack: holds slot, page and valid, compares the
// page against the lookup and flags itself as a replacement candidate.
// ----------------------------------------------------------------------------
module lrupr_cell #(
   parameter int PAGE_BITS = 16,
   parameter int SLOT_W    = 3,
   parameter int LIM_W     = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  lrupr_pkg::cell_ctrl_type ctrl,
   input  logic                    d_valid,
   input  logic [SLOT_W-1:0]       d_slot,
   input  logic [PAGE_BITS-1:0]    d_page,
   input  logic [PAGE_BITS-1:0]    look_page,
   input  logic [LIM_W-1:0]        limit,
   output logic                    q_valid,
   output logic [SLOT_W-1:0]       q_slot,
   output logic [PAGE_BITS-1:0]    q_page,
   output logic                    match,
   output logic                    cand
);

   logic                 valid_ff, valid_in;
   logic [SLOT_W-1:0]    slot_ff, slot_in;
   logic [PAGE_BITS-1:0] page_ff, page_in;

   always_comb begin
      valid_in = valid_ff & ~ctrl.clear;
      slot_in  = slot_ff;
      page_in  = page_ff;
      if (ctrl.load) begin
         valid_in = d_valid;
         slot_in  = d_slot;
         page_in  = d_page;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      slot_ff <= slot_in;
      page_ff <= page_in;
   end

   assign q_valid = valid_ff;
   assign q_slot  = slot_ff;
   assign q_page  = page_ff;
   assign match   = valid_ff && (page_ff == look_page);
   // only slots below the frame limit may be replaced
   assign cand    = valid_ff && (LIM_W'(slot_ff) < limit);

endmodule

// ===== tb/lru_page_replacement_core_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU page replacement core - testbench
// Drives page references through the request channel under random idling on
// both sides, predicts every response with an LRU frame tracker of its own,
// and checks each response field by field in order of arrival.
// ----------------------------------------------------------------------------
module lru_page_replacement_core_tb;

   import lrupr_pkg::*;

   localparam int FRAMES      = 8;
   localparam int PAGE_BITS   = 16;
   localparam int SLOT_W      = 3;
   localparam int CNT_W       = 4;
   localparam int STALL_LIMIT = 2000;   // cycles with no handshake at all

   typedef struct packed {
      logic                 fault;
      logic [SLOT_W-1:0]    slot;
      logic                 evicted_valid;
      logic [PAGE_BITS-1:0] evicted_page;
      logic [CNT_W-1:0]     occupied;
      logic [FAULT_W-1:0]   total;
   } ref_outcome_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [PAGE_BITS-1:0] req_page_number = '0;
   logic                 req_restart = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic                 rsp_fault;
   logic [SLOT_W-1:0]    rsp_frame_slot;
   logic                 rsp_evicted_valid;
   logic [PAGE_BITS-1:0] rsp_evicted_page;
   logic [CNT_W-1:0]     rsp_frames_occupied;
   logic [FAULT_W-1:0]   rsp_fault_total;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CFG_W-1:0]     csr_frames_in_use = '0;

   // frame tracker: our own view of the frame set
   logic [PAGE_BITS-1:0] slot_page [FRAMES] = '{default: '0};
   bit                   slot_used [FRAMES] = '{default: 1'b0};
   int                   slot_age  [FRAMES] = '{default: 0};   // 0 = most recent
   int                   next_fill = 0;
   logic [FAULT_W-1:0]   faults_seen = '0;
   logic [CFG_W-1:0]     frame_limit_reg = CFG_RESET;

   ref_outcome_type pending_outcomes[$];

   int req_idle_pct = 0;
   int rsp_stall_pct = 0;
   int n_errors = 0;
   int n_refs = 0;
   int n_hits = 0;
   int n_evictions = 0;
   int n_csr = 0;
   int idle_cycles = 0;

   lru_page_replacement_core #(
      .FRAMES    (FRAMES),
      .PAGE_BITS (PAGE_BITS)
   ) uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_page_number     (req_page_number),
      .req_restart         (req_restart),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_fault           (rsp_fault),
      .rsp_frame_slot      (rsp_frame_slot),
      .rsp_evicted_valid   (rsp_evicted_valid),
      .rsp_evicted_page    (rsp_evicted_page),
      .rsp_frames_occupied (rsp_frames_occupied),
      .rsp_fault_total     (rsp_fault_total),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_frames_in_use   (csr_frames_in_use)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // ------------------------------------------------------------------------
   // Frame tracker
   // ------------------------------------------------------------------------

   // Slot s becomes most recent; valid frames younger than old_age age by one.
   function automatic void promote(input int s, input int old_age);
      for (int i = 0; i < FRAMES; i++) begin
         if (i != s && slot_used[i] && slot_age[i] < old_age)
            slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   // Applies one reference to the tracker and returns the response it should give.
   function automatic ref_outcome_type lru_lookup(input logic [PAGE_BITS-1:0] page,
                                                  input logic restart);
      ref_outcome_type res;
      int limit;
      int hit_slot;
      int victim;
      int occ;
      res = '0;
      hit_slot = -1;
      occ = 0;
      // restart wipes the frames and the fault total before the lookup
      if (restart) begin
         for (int i = 0; i < FRAMES; i++) begin
            slot_used[i] = 1'b0;
            slot_age[i] = 0;
         end
         next_fill = 0;
         faults_seen = '0;
      end
      // 0 behaves as 1, anything above FRAMES as FRAMES
      limit = frame_limit_reg;
      if (limit < 1) limit = 1;
      if (limit > FRAMES) limit = FRAMES;
      for (int i = 0; i < FRAMES; i++) begin
         if (hit_slot < 0 && slot_used[i] && slot_page[i] == page)
            hit_slot = i;
      end
      if (hit_slot >= 0) begin
         // frames above a lowered limit can still hit
         res.slot = SLOT_W'(hit_slot);
         promote(hit_slot, slot_age[hit_slot]);
      end else begin
         res.fault = 1'b1;
         if (next_fill < limit) begin
            res.slot = SLOT_W'(next_fill);
            slot_used[next_fill] = 1'b1;
            slot_page[next_fill] = page;
            promote(next_fill, FRAMES + 1);
            next_fill++;
         end else begin
            // oldest among the slots under the limit, lowest index on a tie
            victim = 0;
            for (int i = 0; i < limit; i++) begin
               if (slot_age[i] > slot_age[victim])
                  victim = i;
            end
            res.slot = SLOT_W'(victim);
            res.evicted_valid = 1'b1;
            res.evicted_page = slot_page[victim];
            slot_page[victim] = page;
            promote(victim, slot_age[victim]);
         end
         if (faults_seen != FAULT_MAX)
            faults_seen++;
      end
      for (int i = 0; i < FRAMES; i++) begin
         if (slot_used[i]) occ++;
      end
      res.occupied = CNT_W'(occ);
      res.total = faults_seen;
      return res;
   endfunction

   // ------------------------------------------------------------------------
   // Response side: random stall, in-order compare
   // ------------------------------------------------------------------------

   function automatic void check_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
         n_errors++;
      end
   endfunction

   always @(posedge clock) begin : rsp_check
      ref_outcome_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_outcomes.size() == 0) begin
               $error("response with no request outstanding");
               n_errors++;
            end else begin
               want = pending_outcomes.pop_front();
               check_field("fault", 32'(want.fault), 32'(rsp_fault));
               check_field("frame_slot", 32'(want.slot), 32'(rsp_frame_slot));
               check_field("evicted_valid", 32'(want.evicted_valid),
                           32'(rsp_evicted_valid));
               check_field("evicted_page", 32'(want.evicted_page),
                           32'(rsp_evicted_page));
               check_field("frames_occupied", 32'(want.occupied),
                           32'(rsp_frames_occupied));
               check_field("fault_total", 32'(want.total), 32'(rsp_fault_total));
               if (!want.fault) n_hits++;
               if (want.evicted_valid) n_evictions++;
            end
         end
         rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
      end
   end

   // Watchdog: a run that stops moving is a failure.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= STALL_LIMIT) begin
            $display("Timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("Some tests failed");
            $finish;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Request side
   // ------------------------------------------------------------------------

   // One request; valid stays high afterwards so back-to-back requests don't gap.
   task automatic send_ref(input logic [PAGE_BITS-1:0] page, input logic restart);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_page_number <= page;
      req_restart     <= restart;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_outcomes.insert(pending_outcomes.size(), lru_lookup(page, restart));
      n_refs++;
   endtask

   // Drop valid and hold off until every response has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_outcomes.size() != 0) @(posedge clock);
   endtask

   // Register writes only happen with the core idle.
   task automatic write_frame_limit(input logic [CFG_W-1:0] value);
      wait_drained();
      csr_valid         <= 1'b1;
      csr_frames_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      frame_limit_reg = value;
      n_csr++;
      csr_valid <= 1'b0;
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Reset limit of 8: fill every frame, hit, then LRU evictions; page extremes.
   task automatic test_fill_and_hit();
      send_ref(16'h0000, 1'b1);         // restart on an empty set
      for (int i = 1; i < FRAMES; i++)
         send_ref(PAGE_BITS'(i), 1'b0);
      send_ref(16'h0000, 1'b0);         // hit refreshes slot 0
      send_ref(16'hFFFF, 1'b0);         // full: evicts page 1
      send_ref(16'h8000, 1'b0);         // evicts page 2
      send_ref(16'hFFFF, 1'b0);         // hit on a replaced slot
      wait_drained();
   endtask

   // Lowered limit with frames above it resident, 0 and out-of-range values.
   task automatic test_frame_limit();
      write_frame_limit(CFG_W'(3));
      send_ref(16'h0007, 1'b0);         // slot 7 lies above the limit, still hits
      send_ref(16'h1234, 1'b0);         // victim chosen among slots 0..2 only
      write_frame_limit(CFG_W'(0));     // behaves as 1
      send_ref(16'h4321, 1'b0);
      send_ref(16'h2222, 1'b1);         // restart then fill slot 0
      send_ref(16'h3333, 1'b0);         // only slot 0 usable: replace it
      write_frame_limit(CFG_W'(15));    // clamps to FRAMES, filling resumes
      send_ref(16'h4444, 1'b0);
      send_ref(16'h3333, 1'b0);
      write_frame_limit(CFG_W'(9));
      send_ref(16'h5555, 1'b0);
      write_frame_limit(CFG_RESET);
   endtask

   // Bursts over small page pools so hits and evictions both happen, with
   // occasional stray pages, restarts, limit changes and full drains.
   task automatic test_random_traffic(input int n_items);
      logic [PAGE_BITS-1:0] pool [12];
      logic [PAGE_BITS-1:0] page;
      int sent;
      int pool_size;
      int burst_len;
      sent = 0;
      while (sent < n_items) begin
         pool_size = $urandom_range(2, 12);
         foreach (pool[i])
            pool[i] = ($urandom_range(3) == 0) ? PAGE_BITS'($urandom_range(0, 15))
                                               : PAGE_BITS'($urandom_range(0, 65535));
         burst_len = $urandom_range(8, 40);
         for (int k = 0; k < burst_len && sent < n_items; k++) begin
            if ($urandom_range(9) == 0)
               page = PAGE_BITS'($urandom_range(0, 65535));
            else
               page = pool[$urandom_range(0, pool_size - 1)];
            send_ref(page, $urandom_range(24) == 0);
            sent++;
         end
         case ($urandom_range(3))
            0: write_frame_limit(CFG_W'($urandom_range(0, 15)));
            1: wait_drained();
            default: ;
         endcase
      end
      wait_drained();
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sender idles lightly, receiver stalls heavily
      req_idle_pct  = 29;
      rsp_stall_pct = 72;
      test_fill_and_hit();
      test_frame_limit();
      test_random_traffic(135);

      // the other way round
      req_idle_pct  = 72;
      rsp_stall_pct = 29;
      test_random_traffic(135);

      // full rate
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      write_frame_limit(CFG_RESET);
      test_random_traffic(135);

      wait_drained();
      repeat (8) @(posedge clock);

      $display("Covered %0d references: %0d hits, %0d evictions, %0d frame limit writes,",
               n_refs, n_hits, n_evictions, n_csr);
      $display("restarts, limits 0 to 15 and frames resident above a lowered limit,");
      $display("under both stall mixes and at full rate.");
      if (n_errors == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule

// ===== lru_page_replacement_core.f =====
rtl/lrupr_pkg.sv
rtl/lrupr_cell.sv
rtl/lru_page_replacement_core.sv
tb/lru_page_replacement_core_tb.sv
